// File: rtl/orthonormal_basis_3d_top_assert.svh
// Assertion macros for the orthonormal basis block.
`ifndef ORTHONORMAL_BASIS_3D_TOP_ASSERT_SVH
`define ORTHONORMAL_BASIS_3D_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define OB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/obasis_pkg.sv
// ----------------------------------------------------------------------------
// obasis_pkg
// Shared payload types for the orthonormal basis pipeline.
// ----------------------------------------------------------------------------
package obasis_pkg;

  // Input transfer: two vectors, Q16.16
  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } obasis_in_t;

  // Output transfer: three basis vectors and the parallel flag
  typedef struct packed {
    logic signed [31:0] u_x;
    logic signed [31:0] u_y;
    logic signed [31:0] u_z;
    logic signed [31:0] v_x;
    logic signed [31:0] v_y;
    logic signed [31:0] v_z;
    logic signed [31:0] w_x;
    logic signed [31:0] w_y;
    logic signed [31:0] w_z;
    logic               parallel;
  } obasis_out_t;

endpackage

// File: rtl/obasis_norm.sv
// ----------------------------------------------------------------------------
// obasis_norm
// Pipelined vector normalizer: squares, sum, one-bit-per-stage square root,
// then one-bit-per-stage division of each component by the magnitude.
// ----------------------------------------------------------------------------
module obasis_norm
  import obasis_pkg::*;
#(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int TW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 vld_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o,
  output logic [TW-1:0]        tag_o
);

  localparam int MW  = CW;          // magnitude width
  localparam int SW  = 2 * MW + 2;  // sum of squares width
  localparam int RW  = MW + 1;      // root width
  localparam int QW  = FB + 1;      // quotient bits
  localparam int NS  = RW + QW + 1; // index of the last stage
  localparam int DEP = NS;

  // Per-stage payload carried down the pipe
  typedef struct packed {
    logic [2:0]          sgn;
    logic [2:0][MW-1:0]  mag;
    logic [2:0][CW-1:0]  raw;
    logic [SW-1:0]       rem;
    logic [RW-1:0]       root;
    logic [2:0][MW:0]    drem;
    logic [2:0][QW-1:0]  quo;
    logic [TW-1:0]       tag;
  } stg_t;

  stg_t       pipe_q [DEP+1];
  stg_t       s1_d;
  logic [DEP:0] vld_q;

  // Stage 0: register magnitudes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0].sgn  <= {z_i[CW-1], y_i[CW-1], x_i[CW-1]};
    pipe_q[0].mag[0] <= x_i[CW-1] ? MW'(-x_i) : MW'(x_i);
    pipe_q[0].mag[1] <= y_i[CW-1] ? MW'(-y_i) : MW'(y_i);
    pipe_q[0].mag[2] <= z_i[CW-1] ? MW'(-z_i) : MW'(z_i);
    pipe_q[0].raw  <= {z_i, y_i, x_i};
    pipe_q[0].rem  <= '0;
    pipe_q[0].root <= '0;
    pipe_q[0].drem <= '0;
    pipe_q[0].quo  <= '0;
    pipe_q[0].tag  <= tag_i;
  end

  // Stage 1: sum of squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[1] <= 1'b0;
    end else begin
      vld_q[1] <= vld_q[0];
    end
  end

  always_comb begin
    s1_d     = pipe_q[0];
    s1_d.rem = SW'(pipe_q[0].mag[0]) * SW'(pipe_q[0].mag[0])
             + SW'(pipe_q[0].mag[1]) * SW'(pipe_q[0].mag[1])
             + SW'(pipe_q[0].mag[2]) * SW'(pipe_q[0].mag[2]);
  end

  always_ff @(posedge clk_i) begin
    pipe_q[1] <= s1_d;
  end

  // Root and divide stages
  for (genvar s = 2; s <= DEP; s++) begin : g_stage
    stg_t nxt;
    always_comb begin
      logic [SW+1:0] trial;
      logic [MW:0]   dtr;
      int            bi;
      nxt = pipe_q[s-1];
      trial = '0;
      dtr = '0;
      bi = 0;
      if (s < RW + 2) begin
        // Restoring square root, one result bit per stage
        bi = RW - 1 - (s - 2);
        trial = ((SW+2)'(pipe_q[s-1].root) << (bi + 1)) + ((SW+2)'(1) << (2 * bi));
        if (trial <= (SW+2)'(pipe_q[s-1].rem)) begin
          nxt.rem  = pipe_q[s-1].rem - SW'(trial);
          nxt.root = pipe_q[s-1].root | (RW'(1) << bi);
        end
        if (s == RW + 1) begin
          for (int k = 0; k < 3; k++) begin
            nxt.drem[k] = (MW+1)'(pipe_q[s-1].mag[k]);
          end
        end
      end else begin
        // Restoring divide, one quotient bit per stage
        for (int k = 0; k < 3; k++) begin
          dtr = pipe_q[s-1].drem[k];
          nxt.quo[k] = {pipe_q[s-1].quo[k][QW-2:0], 1'b0};
          if (dtr >= (MW+1)'(pipe_q[s-1].root)) begin
            dtr = dtr - (MW+1)'(pipe_q[s-1].root);
            nxt.quo[k][0] = 1'b1;
          end
          nxt.drem[k] = {dtr[MW-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      pipe_q[s] <= nxt;
    end
  end

  // Apply signs; zero magnitude passes input through
  always_comb begin
    logic [2:0][CW-1:0] res;
    for (int k = 0; k < 3; k++) begin
      if (pipe_q[DEP].root == '0) begin
        res[k] = pipe_q[DEP].raw[k];
      end else if (pipe_q[DEP].sgn[k]) begin
        res[k] = CW'(-(CW+QW)'(pipe_q[DEP].quo[k]));
      end else begin
        res[k] = CW'(pipe_q[DEP].quo[k]);
      end
    end
    x_o = res[0];
    y_o = res[1];
    z_o = res[2];
  end

  assign vld_o = vld_q[DEP];
  assign tag_o = pipe_q[DEP].tag;

endmodule

// File: rtl/obasis_cross.sv
// ----------------------------------------------------------------------------
// obasis_cross
// Two-stage cross product: products, then difference, floor shift, saturate.
// ----------------------------------------------------------------------------
module obasis_cross
  import obasis_pkg::*;
#(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int OW = 32
) (
  input  logic                 clk_i,
  input  logic [2:0][CW-1:0]   p_i,
  input  logic [2:0][CW-1:0]   q_i,
  output logic [2:0][OW-1:0]   c_o
);

  localparam int PW = 2 * CW + 1;

  logic signed [5:0][PW-1:0] prod_q;
  logic [2:0][OW-1:0]        c_q;

  // Stage 1: six products
  always_ff @(posedge clk_i) begin
    prod_q[0] <= PW'($signed(p_i[1]) * $signed(q_i[2]));
    prod_q[1] <= PW'($signed(p_i[2]) * $signed(q_i[1]));
    prod_q[2] <= PW'($signed(p_i[2]) * $signed(q_i[0]));
    prod_q[3] <= PW'($signed(p_i[0]) * $signed(q_i[2]));
    prod_q[4] <= PW'($signed(p_i[0]) * $signed(q_i[1]));
    prod_q[5] <= PW'($signed(p_i[1]) * $signed(q_i[0]));
  end

  // Stage 2: difference, shift, clamp
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [PW:0] d;
      logic signed [PW:0] s;
      d = $signed({prod_q[2*k][PW-1], prod_q[2*k]})
        - $signed({prod_q[2*k+1][PW-1], prod_q[2*k+1]});
      s = d >>> FB;
      if (s > $signed((PW+1)'((64'(1) << (OW - 1)) - 1))) begin
        c_q[k] <= {1'b0, {(OW-1){1'b1}}};
      end else if (s < -$signed((PW+1)'(64'(1) << (OW - 1)))) begin
        c_q[k] <= {1'b1, {(OW-1){1'b0}}};
      end else begin
        c_q[k] <= OW'(s);
      end
    end
  end

  assign c_o = c_q;

endmodule

// File: rtl/orthonormal_basis_3d_top.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_3d_top
// Orthonormal basis from two Q16.16 vectors: u = norm(a), w = norm(u x b),
// v = w x u; parallel inputs return u, b, zero and raise the flag.
// ----------------------------------------------------------------------------
// One vector pair is taken every cycle (busy stays low) and each result
// appears once, on done_o, after two normalizer passes (each 2 +
// COMP_WIDTH+1 root stages + FRAC_BITS+1 divide stages) and two two-stage
// cross products. The receiver cannot stall; results must be taken when
// done_o is high.
module orthonormal_basis_3d_top
  import obasis_pkg::*;
#(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  obasis_in_t  in_i,
  output logic        done_o,
  output obasis_out_t out_o
);

`include "orthonormal_basis_3d_top_assert.svh"

  localparam int IW  = (COMP_WIDTH < 32) ? COMP_WIDTH : 32;
  localparam int NL  = COMP_WIDTH + FRAC_BITS + 4; // normalizer latency
  localparam int D2  = NL + 2;                     // delay to second normalize out
  localparam int TW  = 1;

  logic [2:0][COMP_WIDTH-1:0] a_ext, b_ext, u1, c1, w2, v2;
  logic [2:0][IW-1:0]         v_sat;
  logic                       u_vld;
  logic [2:0][COMP_WIDTH-1:0] b_dly_q [NL];
  logic [2:0][COMP_WIDTH-1:0] u_dly_q [D2+1];
  logic [2:0][COMP_WIDTH-1:0] b2_dly_q [D2+1];
  logic                       par_dly_q [2];
  logic [2:0][COMP_WIDTH-1:0] u_at_c_q, b_at_c_q;
  logic                       vld_c_q, vld_c2_q, w_vld, par_c;
  logic [1:0]                 vtail_q;
  logic                       w_tag;
  logic [TW-1:0]              unused_tag;

  assign busy = 1'b0;

  // Sign extend input components
  always_comb begin
    a_ext[0] = COMP_WIDTH'($signed(in_i.a_x[IW-1:0]));
    a_ext[1] = COMP_WIDTH'($signed(in_i.a_y[IW-1:0]));
    a_ext[2] = COMP_WIDTH'($signed(in_i.a_z[IW-1:0]));
    b_ext[0] = COMP_WIDTH'($signed(in_i.b_x[IW-1:0]));
    b_ext[1] = COMP_WIDTH'($signed(in_i.b_y[IW-1:0]));
    b_ext[2] = COMP_WIDTH'($signed(in_i.b_z[IW-1:0]));
  end

  // Normalize a
  obasis_norm #(.CW(COMP_WIDTH), .FB(FRAC_BITS), .TW(TW)) u_norm_a (
    .clk_i, .rst_ni, .vld_i(start), .x_i(a_ext[0]), .y_i(a_ext[1]), .z_i(a_ext[2]),
    .tag_i(1'b0), .vld_o(u_vld), .x_o(u1[0]), .y_o(u1[1]), .z_o(u1[2]),
    .tag_o(unused_tag)
  );

  // Delay b alongside the normalizer
  always_ff @(posedge clk_i) begin
    b_dly_q[0] <= b_ext;
    for (int i = 1; i < NL; i++) begin
      b_dly_q[i] <= b_dly_q[i-1];
    end
  end

  // c = u x b
  obasis_cross #(.CW(COMP_WIDTH), .FB(FRAC_BITS), .OW(COMP_WIDTH)) u_cross_c (
    .clk_i, .p_i(u1), .q_i(b_dly_q[NL-1]), .c_o(c1)
  );

  // Align u, b and valid with c
  always_ff @(posedge clk_i) begin
    u_at_c_q    <= u_dly_q[0];
    b_at_c_q    <= b2_dly_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q  <= 1'b0;
      vld_c2_q <= 1'b0;
    end else begin
      vld_c_q  <= u_vld;
      vld_c2_q <= vld_c_q;
    end
  end

  assign par_c = (c1 == '0);

  // Normalize c
  obasis_norm #(.CW(COMP_WIDTH), .FB(FRAC_BITS), .TW(TW)) u_norm_c (
    .clk_i, .rst_ni, .vld_i(vld_c2_q), .x_i(c1[0]), .y_i(c1[1]), .z_i(c1[2]),
    .tag_i(par_c), .vld_o(w_vld), .x_o(w2[0]), .y_o(w2[1]), .z_o(w2[2]),
    .tag_o(w_tag)
  );

  // Carry u and b beside the cross product and the second normalizer
  always_ff @(posedge clk_i) begin
    u_dly_q[0]   <= u1;
    b2_dly_q[0]  <= b_dly_q[NL-1];
    u_dly_q[1]   <= u_at_c_q;
    b2_dly_q[1]  <= b_at_c_q;
    par_dly_q[0] <= w_tag;
    par_dly_q[1] <= par_dly_q[0];
    for (int i = 2; i < D2 + 1; i++) begin
      u_dly_q[i]   <= u_dly_q[i-1];
      b2_dly_q[i]  <= b2_dly_q[i-1];
    end
  end

  // v = w x u
  obasis_cross #(.CW(COMP_WIDTH), .FB(FRAC_BITS), .OW(IW)) u_cross_v (
    .clk_i, .p_i(w2), .q_i(u_dly_q[NL]), .c_o(v_sat)
  );

  // Valid tail and w alignment through the final cross product
  logic [2:0][COMP_WIDTH-1:0] w_d1_q, w_d2_q;
  logic [2:0][COMP_WIDTH-1:0] u_fin, b_fin;
  logic                       par_fin;
  always_ff @(posedge clk_i) begin
    w_d1_q <= w2;
    w_d2_q <= w_d1_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtail_q <= '0;
    end else begin
      vtail_q <= {vtail_q[0], w_vld};
    end
  end
  assign u_fin   = u_dly_q[D2];
  assign b_fin   = b2_dly_q[D2];
  assign par_fin = par_dly_q[1];
  assign v2      = '0;

  // Saturate to output width
  function automatic logic [31:0] osat(input logic [COMP_WIDTH-1:0] v);
    logic signed [COMP_WIDTH-1:0] s;
    logic signed [COMP_WIDTH:0]   hi, lo;
    s  = $signed(v);
    hi = (COMP_WIDTH+1)'((64'(1) << (IW - 1)) - 1);
    lo = -(COMP_WIDTH+1)'(64'(1) << (IW - 1));
    if ($signed({s[COMP_WIDTH-1], s}) > hi) begin
      osat = 32'(hi);
    end else if ($signed({s[COMP_WIDTH-1], s}) < lo) begin
      osat = 32'(lo);
    end else begin
      osat = 32'(s);
    end
  endfunction

  // Drive the result transfer
  always_comb begin
    done_o         = vtail_q[1];
    out_o.u_x      = osat(u_fin[0]);
    out_o.u_y      = osat(u_fin[1]);
    out_o.u_z      = osat(u_fin[2]);
    out_o.parallel = par_fin;
    if (par_fin) begin
      out_o.v_x = osat(b_fin[0]);
      out_o.v_y = osat(b_fin[1]);
      out_o.v_z = osat(b_fin[2]);
      out_o.w_x = '0;
      out_o.w_y = '0;
      out_o.w_z = '0;
    end else begin
      out_o.v_x = 32'($signed(v_sat[0]));
      out_o.v_y = 32'($signed(v_sat[1]));
      out_o.v_z = 32'($signed(v_sat[2]));
      out_o.w_x = osat(w_d2_q[0] | v2[0]);
      out_o.w_y = osat(w_d2_q[1] | v2[1]);
      out_o.w_z = osat(w_d2_q[2] | v2[2]);
    end
  end

  `OB_ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `OB_ASSERT_IMP(a_par_zero_w, done_o && out_o.parallel, out_o.w_x == '0 && out_o.w_y == '0)
  `OB_ASSERT_NXT(a_done_follows, w_vld, vtail_q[0])

endmodule
